### rtl/core/sha_pkg.sv
`default_nettype none
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenPos = 56;
	localparam logic [7:0] PadMark = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// command bundle from controller to datapath
	typedef struct packed {
		logic       buf_wr;
		logic [5:0] buf_addr;
		logic [7:0] buf_data;
		logic       win_load;
		logic [3:0] win_idx;
		logic       init_work;
		logic       round_en;
		logic [5:0] round;
		logic       fold;
		logic       chain_reset;
	} dp_cmd_t;

	typedef logic [31:0] word_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	localparam word_t RoundConst [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
	};

endpackage
`default_nettype wire

### rtl/core/sha_ram.sv
`default_nettype none
module sha_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(Depth)-1:0] wr_addr,
	input  wire [Width-1:0]         wr_data,
	input  wire [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]        rd_data
);
	logic [Width-1:0] mem_q [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

### rtl/core/sha_datapath.sv
`default_nettype none
module sha_datapath (
	input  wire              clk,
	input  wire              arst_n,
	input  sha_pkg::dp_cmd_t cmd,
	input  wire  [5:0]       rd_addr,
	output logic [7:0]       rd_byte,
	input  wire  [2:0]       out_idx,
	output logic [31:0]      chain_word
);
	import sha_pkg::*;

	word_t win_q [16];
	word_t work_q [8];
	word_t chain_q [8];
	word_t w_new, w_t, t1, t2, s0, s1, w2, w15;
	word_t a, b, c, e, f, g;

	sha_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
		.clk     (clk),
		.wr_en   (cmd.buf_wr),
		.wr_addr (cmd.buf_addr),
		.wr_data (cmd.buf_data),
		.rd_addr (rd_addr),
		.rd_data (rd_byte)
	);

	assign chain_word = chain_q[out_idx];

	// message schedule and round terms: expanded word from the window, t1 and t2
	always_comb begin
		w2  = win_q[4'(cmd.round - 6'd2)];
		w15 = win_q[4'(cmd.round - 6'd15)];
		s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		w_new = s1 + win_q[4'(cmd.round - 6'd7)] + s0 + win_q[cmd.round[3:0]];
		w_t = (cmd.round < 6'd16) ? win_q[cmd.round[3:0]] : w_new;
		a = work_q[0]; b = work_q[1]; c = work_q[2];
		e = work_q[4]; f = work_q[5]; g = work_q[6];
		t1 = work_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ RoundConst[cmd.round] + w_t;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
	end

	// schedule window: byte shift-in during load, new word during rounds
	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			win_q[cmd.win_idx] <= {win_q[cmd.win_idx][23:0], rd_byte};
		end else if (cmd.round_en) begin
			win_q[cmd.round[3:0]] <= w_t;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			for (int i = 0; i < 8; i++) work_q[i] <= chain_q[i];
		end else if (cmd.round_en) begin
			work_q[7] <= g;
			work_q[6] <= f;
			work_q[5] <= e;
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= c;
			work_q[2] <= b;
			work_q[1] <= a;
			work_q[0] <= t1 + t2;
		end
	end

	// chain value: fold or restore
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
		end else if (cmd.chain_reset) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work_q[i];
		end
	end
endmodule
`default_nettype wire

### rtl/core/sha_ctrl.sv
`default_nettype none
module sha_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [7:0]        s_byte,
	input  wire               s_op,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [2:0]        out_idx,
	output logic [5:0]        rd_addr,
	output sha_pkg::dp_cmd_t  cmd
);
	import sha_pkg::*;

	state_t state_q, state_d;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	logic        fin_q;     // finishing a message
	logic        two_q;     // padding needs a second block
	logic [1:0]  phase_q;   // 0 pad fill, 1 compress, 2 length block
	logic [5:0]  pad_q;     // next pad byte address
	logic [6:0]  cnt_q;     // load / round counter
	logic [2:0]  idx_q;
	logic        acc;
	logic [7:0]  pad_byte;

	assign acc = s_tvalid && s_tready;
	assign out_idx = idx_q;
	assign m_tvalid = (state_q == ST_EMIT);

	// byte written while padding
	always_comb begin
		if (phase_q == 2'd0 && pad_q == fill_q) pad_byte = PadMark;
		else if (pad_q >= 6'(LenPos) && !(phase_q == 2'd0 && two_q))
			pad_byte = total_q[6'd63 - {pad_q[2:0], 3'b000} -: 8];
		else pad_byte = 8'h00;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (s_op || fill_q == 6'd63)) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (fin_q && phase_q != 2'd1) begin
					if (pad_q == 6'd63) state_d = ST_LOAD;
				end else if (cnt_q == 7'd64) state_d = ST_ROUND;
			end
			ST_ROUND: if (cnt_q == 7'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (!fin_q) state_d = ST_IDLE;
				else if (phase_q == 2'd1 && two_q) state_d = ST_LOAD;
				else state_d = ST_EMIT;
			end
			ST_EMIT: if (m_tready && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cmd = '0;
		rd_addr = cnt_q[5:0];
		cmd.round = cnt_q[5:0];
		cmd.win_idx = 4'(cnt_q[5:2] - 4'd1);
		case (state_q)
			ST_IDLE: begin
				cmd.buf_wr = acc && !s_op;
				cmd.buf_addr = fill_q;
				cmd.buf_data = s_byte;
			end
			ST_LOAD: begin
				if (fin_q && phase_q != 2'd1) begin
					cmd.buf_wr = 1'b1;
					cmd.buf_addr = pad_q;
					cmd.buf_data = pad_byte;
				end else begin
					cmd.win_load = (cnt_q != 7'd0);
					cmd.win_idx = cnt_q[5:2] - {3'b000, (cnt_q[1:0] == 2'b00)};
					if (cnt_q == 7'd64) cmd.win_idx = 4'd15;
					cmd.init_work = (cnt_q == 7'd64);
				end
			end
			ST_ROUND: cmd.round_en = 1'b1;
			ST_FOLD: cmd.fold = 1'b1;
			ST_EMIT: cmd.chain_reset = m_tready && idx_q == 3'd7;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			total_q <= '0;
			fin_q <= 1'b0;
			two_q <= 1'b0;
			phase_q <= '0;
			pad_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					idx_q <= '0;
					if (acc && !s_op) begin
						fill_q <= fill_q + 6'd1;
						fin_q <= 1'b0;
						phase_q <= 2'd1;
					end else if (acc) begin
						fin_q <= 1'b1;
						total_q <= bits_q + {55'd0, fill_q, 3'b000};
						two_q <= (fill_q >= 6'(LenPos));
						phase_q <= 2'd0;
						pad_q <= fill_q;
					end
				end
				ST_LOAD: begin
					if (fin_q && phase_q != 2'd1) begin
						pad_q <= pad_q + 6'd1;
						// block complete, compress it next
						if (pad_q == 6'd63) phase_q <= 2'd1;
					end else if (cnt_q == 7'd64) cnt_q <= '0;
					else cnt_q <= cnt_q + 7'd1;
				end
				ST_ROUND: cnt_q <= cnt_q + 7'd1;
				ST_FOLD: begin
					cnt_q <= '0;
					if (!fin_q) bits_q <= bits_q + 64'd512;
					else if (phase_q == 2'd1 && two_q) begin
						phase_q <= 2'd2;
						pad_q <= '0;
						two_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							fill_q <= '0;
							bits_q <= '0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/core/sha256_byte_stream_hasher.sv
// channel | dir | tdata                         | tuser   | tlast
// s_axis  | in  | [7:0] data_byte               | op      | -
// m_axis  | out | [31:0] digest_word            | [2:0] word_index | last_word
// An absorb word is written to the block buffer; the 64th byte of a block adds a
// load and 64 rounds (one round per cycle on the single round unit) plus a fold.
// Finish writes the padding byte by byte, runs one or two compressions, then
// presents eight digest words, each held until taken. Reset is asynchronous.
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire         s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);
	import sha_pkg::*;

	dp_cmd_t    cmd;
	logic [2:0] idx;
	logic [5:0] rd_addr;
	logic [7:0] rd_byte;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_byte(s_axis_tdata), .s_op(s_axis_tuser),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.out_idx(idx), .rd_addr(rd_addr), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.rd_addr(rd_addr), .rd_byte(rd_byte),
		.out_idx(idx), .chain_word(m_axis_tdata)
	);

	assign m_axis_tuser = idx;
	assign m_axis_tlast = (idx == 3'd7);
endmodule
`default_nettype wire

### verif/sha256_digest_checker.sv
`default_nettype none
module sha256_digest_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	input  wire        s_axis_tready,
	input  wire  [7:0] s_axis_tdata,
	input  wire        s_axis_tuser,
	input  wire        m_axis_tvalid,
	input  wire        m_axis_tready,
	input  wire [31:0] m_axis_tdata,
	input  wire  [2:0] m_axis_tuser,
	input  wire        m_axis_tlast,
	output int         fail_count,
	output int         pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ABSORB = 1'b0;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
	};
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
	};

	logic [7:0]  msg_block [64];
	logic [5:0]  fill;
	logic [63:0] bit_total;
	logic [31:0] hash_state [8];
	digest_beat_t digest_queue [$];

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// fold msg_block into hash_state
	task automatic sha_compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	// absorb a byte or pad and queue the digest
	task automatic hash_word(logic op, logic [7:0] b);
		logic [63:0] total;
		int pos;
		if (op == OP_ABSORB) begin
			msg_block[fill] = b;
			fill = fill + 6'd1;
			if (fill == 0) begin
				sha_compress();
				bit_total += 64'd512;
			end
		end else begin
			pos = fill;
			total = bit_total + 64'(pos) * 8;
			msg_block[pos] = 8'h80;
			for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
			if (pos >= 56) begin
				sha_compress();
				for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++) msg_block[56 + i] = total[63 - 8*i -: 8];
			sha_compress();
			for (int i = 0; i < 8; i++)
				digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
			for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
			fill = 0;
			bit_total = 0;
		end
	endtask

	initial begin
		fail_count = 0;
		pending_words = 0;
		fill = 0;
		bit_total = 0;
		for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
		for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
	end

	// check outputs first, then predict from the input
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_queue.size() == 0) begin
					$error("unexpected digest word %h", m_axis_tdata);
					fail_count++;
				end else begin
					exp_beat = digest_queue.pop_front();
					if (m_axis_tdata !== exp_beat.digest_word) begin
						$error("digest_word exp %h got %h", exp_beat.digest_word, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser !== exp_beat.word_index) begin
						$error("word_index exp %0d got %0d", exp_beat.word_index, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tlast !== exp_beat.last_word) begin
						$error("last_word exp %0d got %0d", exp_beat.last_word, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				hash_word(s_axis_tuser, s_axis_tdata);
			pending_words = digest_queue.size();
		end
	end
endmodule
`default_nettype wire

### verif/sha256_byte_stream_hasher_test.sv
`default_nettype none
module sha256_byte_stream_hasher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending_words;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off = 0;

	sha256_byte_stream_hasher DUT (.*);
	sha256_digest_checker digest_check (.*);

	always #5 clk = ~clk;

	// receiver: random stall, or a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (600) @(negedge clk);
				hold_off = 0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(logic op, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// random message bytes, then finish
	task automatic send_message(int len);
		for (int i = 0; i < len; i++) send_word(OP_ABSORB, 8'($urandom));
		send_word(OP_FINISH, 8'($urandom));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: empty, byte extremes, finish data ignored
		send_word(OP_FINISH, 8'h00);
		send_word(OP_ABSORB, 8'h00);
		send_word(OP_FINISH, 8'hff);
		send_word(OP_ABSORB, 8'hff);
		send_word(OP_ABSORB, 8'h55);
		send_word(OP_FINISH, 8'haa);
		// hold off receiver while back-to-back finishes pile up
		hold_off = 1;
		for (int i = 0; i < 3; i++) send_word(OP_FINISH, 8'($urandom));
		// random phases; the long message fills one block and leaves 56 bytes,
		// so its padding takes two compressions
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			if (ph == 1) send_message(120);
			else repeat (2) send_message($urandom_range(2));
		end
		s_axis_tvalid <= 0;
		while (pending_words != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("** sha256_byte_stream_hasher: PASSED **");
		else
			$display("** sha256_byte_stream_hasher: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** sha256_byte_stream_hasher: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
rtl/core/sha_pkg.sv
rtl/core/sha_ram.sv
rtl/core/sha_datapath.sv
rtl/core/sha_ctrl.sv
rtl/core/sha256_byte_stream_hasher.sv
verif/sha256_digest_checker.sv
verif/sha256_byte_stream_hasher_test.sv
